// ===== design/ktbl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ktbl_pkg;

    localparam int NUM_SLOTS      = 256;
    localparam int KEY_BITS       = 8;
    localparam int TIME_BITS      = 32;
    localparam int CREDIT_BITS    = 31;
    localparam int CAP_BITS       = 10;
    localparam int PERIOD_BITS    = 20;
    localparam int TICKS_BITS     = CAP_BITS + PERIOD_BITS;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 20;
    localparam int S_TDATA_BITS   = 40;
    localparam int M_TDATA_BITS   = 8;

    localparam logic [CFG_INDEX_BITS-1:0] REG_BUCKET_CAPACITY = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REFILL_PERIOD   = 1'd1;

    localparam logic [CAP_BITS-1:0]    CAP_RESET    = 10'd10;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 20'd60;
    localparam logic [TICKS_BITS-1:0]  TICKS_RESET  = 30'd600;
    localparam logic [TICKS_BITS-1:0]  SEED_RESET   = 30'd540;

    typedef struct packed {
        logic [CREDIT_BITS-1:0] credit;
        logic [TIME_BITS-1:0]   last_time;
    } slot_t;

    localparam int SLOT_BITS = CREDIT_BITS + TIME_BITS;

    // Derived bucket limits, refreshed whenever a register is written
    typedef struct packed {
        logic [PERIOD_BITS-1:0] period;
        logic [TICKS_BITS-1:0]  cap_ticks;
        logic [TICKS_BITS-1:0]  seed;
    } limits_t;

endpackage

`default_nettype wire

// ===== design/keyed_token_bucket_limiter.sv =====
// Keyed token-bucket limiter.
// Slave stream: one request per transfer, s_tdata = key_index [7:0], now_time [39:8].
// Master stream: one decision per request, m_tdata[0] = allowed, upper bits zero.
// Config channel: cfg_index 0 writes bucket_capacity (cfg_data[9:0]), index 1 writes
// refill_period (cfg_data[19:0]); cfg_ready is always high. Write only while idle.
// Each of 256 slots keeps a credit in ticks and its last refill time in a
// single-port-write, registered-read table, plus a valid flag in flip-flops.
// A request is registered in the request stage, then its decision in the result register.
// Throughput: one request per cycle unless m_tready stalls; a request to the slot updated
// at the same edge takes the fresh slot value from a bypass register instead of the table.
// Reset clears every valid flag at once (no sweep) and loads capacity 10, period 60;
// the first request to a slot seeds it with capacity - 1 tokens and is admitted.
// When m_tready is low the result register holds, the request stage holds behind it,
// and s_tready drops once both are full.
`timescale 1ns / 1ps
`default_nettype none

module keyed_token_bucket_limiter (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // key_index [7:0], now_time [39:8]
    input  wire logic [ktbl_pkg::S_TDATA_BITS-1:0]   s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // allowed [0], zero fill [7:1]
    output logic      [ktbl_pkg::M_TDATA_BITS-1:0]   m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ktbl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [ktbl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    ktbl_pkg::limits_t limits;

    logic [ktbl_pkg::KEY_BITS-1:0]  s_key;
    logic [ktbl_pkg::TIME_BITS-1:0] s_now;
    logic                           s_accept;
    logic                           s1_move;
    logic                           hazard;

    logic                           s1_valid_reg, s1_valid_next;
    logic [ktbl_pkg::KEY_BITS-1:0]  s1_key_reg;
    logic [ktbl_pkg::TIME_BITS-1:0] s1_now_reg;
    logic                           s1_fwd_reg;
    ktbl_pkg::slot_t                s1_fwd_slot_reg;

    logic [ktbl_pkg::NUM_SLOTS-1:0] valid_reg, valid_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_allowed_reg;

    logic [ktbl_pkg::SLOT_BITS-1:0] rd_data;
    ktbl_pkg::slot_t                slot_old;
    ktbl_pkg::slot_t                slot_new;
    logic                           slot_is_valid;
    logic                           allowed;

    assign s_key     = s_tdata[ktbl_pkg::KEY_BITS-1:0];
    assign s_now     = s_tdata[ktbl_pkg::KEY_BITS +: ktbl_pkg::TIME_BITS];
    assign cfg_ready = 1'b1;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_move;
    assign s_accept = s_tvalid && s_tready;
    // the table read at this edge misses the write of the same edge
    assign hazard   = s1_move && (s1_key_reg == s_key);

    ktbl_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    ktbl_ram #(
        .WIDTH (ktbl_pkg::SLOT_BITS),
        .DEPTH (ktbl_pkg::NUM_SLOTS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (s1_move),
        .wr_addr (s1_key_reg),
        .wr_data (slot_new),
        .rd_en   (s_accept),
        .rd_addr (s_key),
        .rd_data (rd_data)
    );

    assign slot_old      = s1_fwd_reg ? s1_fwd_slot_reg : ktbl_pkg::slot_t'(rd_data);
    assign slot_is_valid = s1_fwd_reg || valid_reg[s1_key_reg];

    ktbl_update u_update (
        .limits     (limits),
        .slot_valid (slot_is_valid),
        .slot_old   (slot_old),
        .now_time   (s1_now_reg),
        .allowed    (allowed),
        .slot_new   (slot_new)
    );

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        valid_next     = valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (s1_move) begin
            s1_valid_next          = 1'b0;
            out_valid_next         = 1'b1;
            valid_next[s1_key_reg] = 1'b1;
        end
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_key_reg      <= s_key;
            s1_now_reg      <= s_now;
            s1_fwd_reg      <= hazard;
            s1_fwd_slot_reg <= slot_new;
        end
        if (s1_move) begin
            out_allowed_reg <= allowed;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ktbl_pkg::M_TDATA_BITS-1){1'b0}}, out_allowed_reg};

    // a retired request leaves its slot marked valid
    a_valid_set: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_move |=> valid_reg[$past(s1_key_reg)])
        else $error("slot valid flag not set after update");

    // bypass only ever stands in for a slot that is already valid
    a_fwd_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_fwd_reg) |-> valid_reg[s1_key_reg])
        else $error("bypass used for an invalid slot");

    // same-slot request behind an update must take the bypass
    a_fwd_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s1_move && (s1_key_reg == s_key)) |=> s1_fwd_reg)
        else $error("same-slot hazard missed the bypass");

    // first touch of a slot is always admitted
    a_first_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_move && !valid_reg[s1_key_reg] && !s1_fwd_reg) |=> (m_tvalid && m_tdata[0]))
        else $error("first request to a slot rejected");

endmodule

`default_nettype wire

// ===== design/ktbl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ktbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/ktbl_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ktbl_cfg (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    input  wire logic [ktbl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [ktbl_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output ktbl_pkg::limits_t                        limits
);

    logic [ktbl_pkg::CAP_BITS-1:0]    cap_reg, cap_next;
    logic [ktbl_pkg::PERIOD_BITS-1:0] period_reg, period_next;
    logic [ktbl_pkg::TICKS_BITS-1:0]  ticks_reg, ticks_next;
    logic [ktbl_pkg::TICKS_BITS-1:0]  seed_reg, seed_next;
    logic [ktbl_pkg::CAP_BITS-1:0]    cap_dec;

    always_comb begin
        cap_next    = cap_reg;
        period_next = period_reg;
        if (cfg_valid) begin
            case (cfg_index)
                ktbl_pkg::REG_BUCKET_CAPACITY: begin
                    cap_next = cfg_data[ktbl_pkg::CAP_BITS-1:0];
                end
                ktbl_pkg::REG_REFILL_PERIOD: begin
                    period_next = cfg_data[ktbl_pkg::PERIOD_BITS-1:0];
                end
                default: begin
                    cap_next = cap_reg;
                end
            endcase
        end
    end

    // Compute the limits from the incoming values so they settle at the write edge
    always_comb begin
        cap_dec    = cap_next - ktbl_pkg::CAP_BITS'(1);
        ticks_next = ktbl_pkg::TICKS_BITS'(cap_next) * ktbl_pkg::TICKS_BITS'(period_next);
        if (cap_next == '0) begin
            seed_next = '0;
        end else begin
            seed_next = ktbl_pkg::TICKS_BITS'(cap_dec) * ktbl_pkg::TICKS_BITS'(period_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= ktbl_pkg::CAP_RESET;
            period_reg <= ktbl_pkg::PERIOD_RESET;
            ticks_reg  <= ktbl_pkg::TICKS_RESET;
            seed_reg   <= ktbl_pkg::SEED_RESET;
        end else begin
            cap_reg    <= cap_next;
            period_reg <= period_next;
            ticks_reg  <= ticks_next;
            seed_reg   <= seed_next;
        end
    end

    assign limits.period    = period_reg;
    assign limits.cap_ticks = ticks_reg;
    assign limits.seed      = seed_reg;

endmodule

`default_nettype wire

// ===== design/ktbl_update.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ktbl_update (
    input  wire ktbl_pkg::limits_t              limits,
    input  wire logic                           slot_valid,
    input  wire ktbl_pkg::slot_t                slot_old,
    input  wire logic [ktbl_pkg::TIME_BITS-1:0] now_time,
    output logic                                allowed,
    output ktbl_pkg::slot_t                     slot_new
);

    logic [ktbl_pkg::TIME_BITS-1:0]  elapsed;
    logic [ktbl_pkg::TIME_BITS-1:0]  sum;
    logic [ktbl_pkg::TICKS_BITS-1:0] filled;
    logic [ktbl_pkg::TICKS_BITS-1:0] period_ext;

    always_comb begin
        period_ext = ktbl_pkg::TICKS_BITS'(limits.period);
        elapsed    = now_time - slot_old.last_time;
        // the sum is only used while elapsed is below the cap, where it cannot overflow
        sum        = ktbl_pkg::TIME_BITS'(slot_old.credit) + elapsed;
        if (elapsed >= ktbl_pkg::TIME_BITS'(limits.cap_ticks)) begin
            filled = limits.cap_ticks;
        end else if (sum > ktbl_pkg::TIME_BITS'(limits.cap_ticks)) begin
            filled = limits.cap_ticks;
        end else begin
            filled = sum[ktbl_pkg::TICKS_BITS-1:0];
        end

        slot_new.last_time = now_time;
        if (!slot_valid) begin
            // first request seeds one token short of full
            allowed         = 1'b1;
            slot_new.credit = ktbl_pkg::CREDIT_BITS'(limits.seed);
        end else if (filled >= period_ext) begin
            allowed         = 1'b1;
            slot_new.credit = ktbl_pkg::CREDIT_BITS'(filled - period_ext);
        end else begin
            allowed         = 1'b0;
            slot_new.credit = ktbl_pkg::CREDIT_BITS'(filled);
        end
    end

endmodule

`default_nettype wire
